[src/ffa_pkg.sv]
// Package with the arena constants, opcodes and controller states of the allocator.
package ffa_pkg;
   localparam int ARENA_BYTES  = 2048;
   localparam int HEADER_BYTES = 24;
   localparam int OFF_W        = $clog2(ARENA_BYTES);
   localparam int LINK_W       = OFF_W + 1;
   localparam int SIZE_W       = OFF_W;
   localparam int STEP_W       = OFF_W + 2;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(ARENA_BYTES);
   localparam logic [SIZE_W-1:0] WHOLE_SIZE = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_SPLIT,
      ST_UNLINK,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_FREE_MRG,
      ST_DONE
   } state_type;
endpackage

[src/first_fit_free_list_allocator.sv]
// First-fit free-list allocator: header memories, list walk sequencer and response register.
// An allocate reads and checks each visited free block, then splits and unlinks the chosen
// one; a free reads the block, links it to the old head and reads that head for a merge; a
// zero request or an ignored free goes to the result. One request at a time; the next one
// is taken as the response appears; a response still held in the output register stalls it.
// Reset clears the head pointer and control; entry 0 reads through a valid flag overlay.
module first_fit_free_list_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // request_bytes[10:0], payload_offset[21:11], zeros
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // granted_offset[10:0], zeros
   output logic        rsp_tuser    // status
);
   localparam int OW = ffa_pkg::OFF_W;
   localparam int LW = ffa_pkg::LINK_W;
   localparam int SW = ffa_pkg::SIZE_W;
   localparam logic [LW-1:0] HDR_L = LW'(ffa_pkg::HEADER_BYTES);

   logic [SW-1:0] size_mem [ffa_pkg::ARENA_BYTES];
   logic [LW-1:0] link_mem [ffa_pkg::ARENA_BYTES];

   ffa_pkg::state_type state_ff, state_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in, nxt_ff, nxt_in;
   logic [SW-1:0] req_ff, req_in, bsize_ff, bsize_in;
   logic [LW-1:0] blink_ff, blink_in;
   logic [ffa_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic          e0_ff, e0_in;    // entry 0 still holds its reset contents
   logic          rv_ff, rv_in, rs_ff, rs_in;
   logic [OW-1:0] rg_ff, rg_in;
   logic          os_ff, os_in;
   logic [OW-1:0] og_ff, og_in;

   logic          rd_en;
   logic [OW-1:0] rd_addr, rd_addr_ff;
   logic [SW-1:0] rd_size_q, rd_size;
   logic [LW-1:0] rd_link_q, rd_link;
   logic          we_s, we_l, we2_s, we2_l;
   logic [OW-1:0] wa, wa2;
   logic [SW-1:0] wd_s, wd2_s;
   logic [LW-1:0] wd_l, wd2_l;
   logic [LW:0]   rest_w, sum_w;
   logic [SW:0]   merged_w;

   // Both write ports are used together only at split time, on different entries.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_size_q  <= size_mem[rd_addr];
         rd_link_q  <= link_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (we_s) size_mem[wa] <= wd_s;
      if (we_l) link_mem[wa] <= wd_l;
      if (we2_s) size_mem[wa2] <= wd2_s;
      if (we2_l) link_mem[wa2] <= wd2_l;
   end

   assign rd_size = (e0_ff && rd_addr_ff == '0) ? ffa_pkg::WHOLE_SIZE : rd_size_q;
   assign rd_link = (e0_ff && rd_addr_ff == '0) ? ffa_pkg::LINK_NULL : rd_link_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::ST_IDLE;
         head_ff  <= '0;
         e0_ff    <= 1'b1;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         e0_ff    <= e0_in;
         rv_ff    <= rv_in;
      end
      cur_ff <= cur_in; prev_ff <= prev_in; nxt_ff <= nxt_in;
      req_ff <= req_in; bsize_ff <= bsize_in; blink_ff <= blink_in;
      steps_ff <= steps_in; rs_ff <= rs_in; rg_ff <= rg_in;
      os_ff <= os_in; og_ff <= og_in;
   end

   assign rest_w   = {1'b0, cur_ff} + {1'b0, HDR_L} + (LW+1)'(req_ff);
   assign sum_w    = {1'b0, cur_ff} + (LW+1)'(bsize_ff) + {1'b0, HDR_L};
   assign merged_w = (SW+1)'(bsize_ff) + (SW+1)'(rd_size) + (SW+1)'(ffa_pkg::HEADER_BYTES);

   always_comb begin
      state_in = state_ff; head_in = head_ff; e0_in = e0_ff;
      cur_in = cur_ff; prev_in = prev_ff; nxt_in = nxt_ff;
      req_in = req_ff; bsize_in = bsize_ff; blink_in = blink_ff;
      steps_in = steps_ff; rs_in = rs_ff; rg_in = rg_ff;
      os_in = os_ff; og_in = og_ff;
      rv_in = rv_ff && !rsp_tready;
      rd_en = 1'b0; rd_addr = cur_ff[OW-1:0];
      we_s = 1'b0; we_l = 1'b0; we2_s = 1'b0; we2_l = 1'b0;
      wa = cur_ff[OW-1:0]; wa2 = rest_w[OW-1:0];
      wd_s = req_ff; wd_l = blink_ff; wd2_s = '0; wd2_l = blink_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               req_in   = req_tdata[10:0];
               steps_in = '0;
               prev_in  = ffa_pkg::LINK_NULL;
               cur_in   = head_ff;
               rs_in    = 1'b0;
               rg_in    = '0;
               if (ffa_pkg::opcode_type'(req_tuser) == ffa_pkg::OP_FREE) begin
                  if (req_tdata[21:11] < OW'(ffa_pkg::HEADER_BYTES)) begin
                     state_in = ffa_pkg::ST_DONE;
                  end else begin
                     cur_in   = {1'b0, req_tdata[21:11] - OW'(ffa_pkg::HEADER_BYTES)};
                     state_in = ffa_pkg::ST_FREE_RD;
                  end
               end else if (req_tdata[10:0] == '0) begin
                  rs_in = 1'b1; state_in = ffa_pkg::ST_DONE;
               end else begin
                  state_in = ffa_pkg::ST_WALK_RD;
               end
            end
         end
         ffa_pkg::ST_WALK_RD: begin
            if (cur_ff[LW-1]) begin
               rs_in = 1'b1; state_in = ffa_pkg::ST_DONE;
            end else begin
               rd_en = 1'b1; state_in = ffa_pkg::ST_WALK_CHK;
            end
         end
         ffa_pkg::ST_WALK_CHK: begin
            bsize_in = rd_size; blink_in = rd_link;
            if (rd_size >= req_ff) begin
               state_in = ffa_pkg::ST_SPLIT;
            end else if (steps_ff >= ffa_pkg::STEP_W'(ffa_pkg::ARENA_BYTES)) begin
               rs_in = 1'b1; state_in = ffa_pkg::ST_DONE;
            end else begin
               steps_in = steps_ff + 1'b1;
               prev_in  = cur_ff;
               cur_in   = rd_link;
               state_in = ffa_pkg::ST_WALK_RD;
            end
         end
         ffa_pkg::ST_SPLIT: begin
            if ((SW+1)'(bsize_ff) > (SW+1)'(req_ff) + (SW+1)'(ffa_pkg::HEADER_BYTES)
                && rest_w < (LW+1)'(ffa_pkg::ARENA_BYTES)) begin
               we_s = 1'b1; we_l = 1'b1; wd_s = req_ff; wd_l = rest_w[LW-1:0];
               we2_s = 1'b1; we2_l = 1'b1;
               wd2_s = bsize_ff - req_ff - SW'(ffa_pkg::HEADER_BYTES);
               wd2_l = blink_ff;
               if (cur_ff[OW-1:0] == '0 || rest_w[OW-1:0] == '0) e0_in = 1'b0;
               blink_in = rest_w[LW-1:0];
            end
            state_in = ffa_pkg::ST_UNLINK;
         end
         ffa_pkg::ST_UNLINK: begin
            if (prev_ff[LW-1]) begin
               head_in = blink_ff;
            end else begin
               we_l = 1'b1; wa = prev_ff[OW-1:0]; wd_l = blink_ff;
               if (prev_ff[OW-1:0] == '0 && e0_ff) begin
                  we_s = 1'b1; wd_s = ffa_pkg::WHOLE_SIZE; e0_in = 1'b0;
               end
            end
            rg_in    = cur_ff[OW-1:0] + OW'(ffa_pkg::HEADER_BYTES);
            state_in = ffa_pkg::ST_DONE;
         end
         ffa_pkg::ST_FREE_RD: begin
            // The block's own size, then its list successor once linked to the old head.
            rd_en = 1'b1; nxt_in = head_ff; state_in = ffa_pkg::ST_FREE_CHK;
         end
         ffa_pkg::ST_FREE_CHK: begin
            bsize_in = rd_size;
            we_l = 1'b1; wd_l = nxt_ff; head_in = cur_ff;
            if (cur_ff[OW-1:0] == '0 && e0_ff) begin
               we_s = 1'b1; wd_s = rd_size; e0_in = 1'b0;
            end
            rd_addr = nxt_ff[OW-1:0];
            if (!nxt_ff[LW-1] && nxt_ff[OW-1:0] != cur_ff[OW-1:0]) begin
               rd_en = 1'b1; state_in = ffa_pkg::ST_FREE_MRG;
            end else begin
               state_in = ffa_pkg::ST_DONE;
            end
         end
         ffa_pkg::ST_FREE_MRG: begin
            if (sum_w == {1'b0, nxt_ff}) begin
               we_s = 1'b1; we_l = 1'b1; wd_l = rd_link;
               wd_s = (merged_w > (SW+1)'(ffa_pkg::WHOLE_SIZE)) ? ffa_pkg::WHOLE_SIZE
                                                                : merged_w[SW-1:0];
            end
            state_in = ffa_pkg::ST_DONE;
         end
         ffa_pkg::ST_DONE: begin
            // The finished result moves to the output register once it is free.
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1; os_in = rs_ff; og_in = rg_ff;
               state_in = ffa_pkg::ST_IDLE;
            end
         end
         default: state_in = ffa_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = os_ff;
   assign rsp_tdata  = {5'b0, og_ff};

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("failed allocation with nonzero offset");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ffa_pkg::ST_IDLE)
      else $error("request taken while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
endmodule

[dv/ffa_checker.sv]
// Checker for the allocator: mirrors the free list, predicts each response and compares.
`timescale 1ns / 100ps

module ffa_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic                      status;
      logic [ffa_pkg::OFF_W-1:0] granted;
   } alloc_result_type;

   int               block_size [ffa_pkg::ARENA_BYTES];
   int               block_link [ffa_pkg::ARENA_BYTES];
   int               list_head;
   alloc_result_type expected_grants[$];

   // First-fit walk with predecessor tracking; returns the payload offset or -1.
   function automatic int first_fit_take(int want);
      int prev, cur, steps, rest;
      prev  = ffa_pkg::ARENA_BYTES;
      cur   = list_head;
      steps = 0;
      if (want == 0) return -1;
      while (cur < ffa_pkg::ARENA_BYTES && block_size[cur] < want) begin
         steps++;
         if (steps > ffa_pkg::ARENA_BYTES) return -1;
         prev = cur;
         cur  = block_link[cur];
      end
      if (cur >= ffa_pkg::ARENA_BYTES) return -1;
      if (block_size[cur] > want + ffa_pkg::HEADER_BYTES) begin
         rest = cur + ffa_pkg::HEADER_BYTES + want;
         if (rest < ffa_pkg::ARENA_BYTES) begin
            block_size[rest] = block_size[cur] - want - ffa_pkg::HEADER_BYTES;
            block_link[rest] = block_link[cur];
            block_size[cur]  = want;
            block_link[cur]  = rest;
         end
      end
      if (prev < ffa_pkg::ARENA_BYTES) block_link[prev] = block_link[cur];
      else list_head = block_link[cur];
      return cur + ffa_pkg::HEADER_BYTES;
   endfunction

   function automatic void release_block(int payload);
      int blk, nxt, merged;
      if (payload < ffa_pkg::HEADER_BYTES) return;
      blk = payload - ffa_pkg::HEADER_BYTES;
      if (blk >= ffa_pkg::ARENA_BYTES) return;
      block_link[blk] = list_head;
      list_head       = blk;
      nxt             = block_link[blk];
      if (nxt < ffa_pkg::ARENA_BYTES && blk + block_size[blk] + ffa_pkg::HEADER_BYTES == nxt)
      begin
         merged = block_size[blk] + block_size[nxt] + ffa_pkg::HEADER_BYTES;
         if (merged > ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES)
            merged = ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES;
         block_size[blk] = merged;
         block_link[blk] = block_link[nxt];
      end
   endfunction

   always @(posedge clock) begin
      alloc_result_type exp_r;
      int               got;
      if (reset) begin
         foreach (block_size[i]) begin
            block_size[i] = 0;
            block_link[i] = 0;
         end
         block_size[0] = ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES;
         block_link[0] = ffa_pkg::ARENA_BYTES;
         list_head     = 0;
         fail_count    = 0;
         expected_grants.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            exp_r = '0;
            if (ffa_pkg::opcode_type'(req_tuser) == ffa_pkg::OP_ALLOC) begin
               got = first_fit_take(int'(req_tdata[10:0]));
               if (got < 0) exp_r.status = 1'b1;
               else exp_r.granted = ffa_pkg::OFF_W'(got);
            end else begin
               release_block(int'(req_tdata[21:11]));
            end
            expected_grants.push_back(exp_r);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_grants.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no request outstanding", $realtime);
            end else begin
               exp_r = expected_grants.pop_front();
               if (rsp_tuser !== exp_r.status || rsp_tdata[10:0] !== exp_r.granted
                   || rsp_tdata[15:11] !== 5'd0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch status exp %0d got %0d, offset exp %0d got %0d",
                              $realtime, exp_r.status, rsp_tuser, exp_r.granted,
                              rsp_tdata[10:0]);
               end
            end
         end
      end
      pending_count = expected_grants.size();
   end

endmodule

[dv/tb_first_fit_free_list_allocator.sv]
// Testbench top for the allocator: clock, reset, request stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_first_fit_free_list_allocator;

   localparam int STALL_LIMIT = 40000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   int          fail_count;
   int          pending_count;
   bit          steady;
   int          quiet_cycles;
   int          alloc_sent, free_sent, grants_seen;
   int          live_blocks[$];
   int          granted_ever[$];

   first_fit_free_list_allocator u_dut (.*);

   ffa_checker u_checker (.*);

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ffa_pkg::OP_ALLOC;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(99) >= 31);
   end

   // Granted offsets are collected so that frees only name real blocks.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[10:0] != 0) begin
         live_blocks.push_back(int'(rsp_tdata[10:0]));
         granted_ever.push_back(int'(rsp_tdata[10:0]));
         grants_seen++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_request(ffa_pkg::opcode_type op, int bytes, int payload);
      while (!steady && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, 11'(payload), 11'(bytes)};
      if (op == ffa_pkg::OP_ALLOC) alloc_sent++;
      else free_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic alloc_request(int bytes);
      send_request(ffa_pkg::OP_ALLOC, bytes, $urandom_range(2047));
   endtask

   task automatic free_request(int payload);
      send_request(ffa_pkg::OP_FREE, $urandom_range(2047), payload);
   endtask

   // The extra edge lets every process of the last response edge finish first.
   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   function automatic int pick_live();
      int idx, val;
      idx = $urandom_range(live_blocks.size() - 1);
      val = live_blocks[idx];
      live_blocks.delete(idx);
      return val;
   endfunction

   function automatic int random_request_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(120, 1);
      if (r < 85) return $urandom_range(600, 121);
      if (r < 90) return 0;
      return $urandom_range(2047);
   endfunction

   initial begin
      int r;
      wait (reset == 1'b0);
      @(posedge clock);

      // Zero request, oversize request, whole arena, one byte with the arena full, then release it.
      alloc_request(0);
      alloc_request(2047);
      alloc_request(ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES);
      alloc_request(1);
      drain;
      free_request(pick_live());
      // Small splits, then frees in reverse address order so that neighbors merge.
      alloc_request(1);
      alloc_request(100);
      alloc_request(50);
      alloc_request(2000);
      drain;
      while (live_blocks.size() != 0) free_request(live_blocks.pop_back());
      // Offsets below one header are ignored.
      free_request(0);
      free_request(23);
      alloc_request(1024);
      alloc_request(1023);
      alloc_request(977);
      drain;
      while (live_blocks.size() != 0) free_request(live_blocks.pop_front());
      drain;

      for (int n = 0; n < 1750; n++) begin
         steady = (n >= 600 && n < 850);
         r = $urandom_range(199);
         if (r == 0 && granted_ever.size() != 0) begin
            // Occasional double free; the list may then turn cyclic.
            drain;
            free_request(granted_ever[$urandom_range(granted_ever.size() - 1)]);
         end else if (r == 1) begin
            free_request($urandom_range(ffa_pkg::HEADER_BYTES - 1));
         end else if (live_blocks.size() != 0 && r < 95) begin
            free_request(pick_live());
         end else begin
            alloc_request(random_request_size());
         end
      end
      steady = 1'b0;
      drain;
      repeat (50) @(posedge clock);

      $display("Sent %0d allocate and %0d free requests; %0d grants returned.",
               alloc_sent, free_sent, grants_seen);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
